// File: hw/rtl/atbl_pkg.sv
`default_nettype none
package atbl_pkg;

  localparam int unsigned NowW   = 32;
  localparam int unsigned RawW   = 16;
  localparam int unsigned SpeedW = 25;
  localparam int unsigned FiltW  = 24;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 16;

  localparam logic [7:0] AlphaNum = 8'd218;
  localparam logic [7:0] AlphaRem = 8'd38;
  localparam logic [SpeedW-1:0] SpeedMax = 25'd23390000;
  localparam logic [SpeedW-1:0] SpeedAutoMin = 25'd835352;
  localparam logic [8:0] StillLsb = 9'd251;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ALONG_BIAS   = 3'd0,
    REG_LATERAL_BIAS = 3'd1,
    REG_HAZARD_ON    = 3'd2,
    REG_MANUAL_TURN  = 3'd3,
    REG_TURN_THR     = 3'd4,
    REG_BRAKE_THR    = 3'd5,
    REG_BLINK_HALF   = 3'd6,
    REG_HOLD         = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    TURN_OFF   = 2'd0,
    TURN_LEFT  = 2'd1,
    TURN_RIGHT = 2'd2,
    TURN_NONE  = 2'd3
  } turn_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FILT,
    ST_SPEED,
    ST_MAG,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [NowW-1:0]        now_ms;
    logic signed [RawW-1:0] accel_along_raw;
    logic signed [RawW-1:0] accel_lateral_raw;
    logic                   sample_valid;
  } in_word_t;

  typedef struct packed {
    logic                    turn_left;
    logic                    turn_right;
    logic                    tail_light;
    logic [SpeedW-1:0]       speed_estimate;
    logic signed [FiltW-1:0] along_filtered;
    logic signed [FiltW-1:0] lateral_filtered;
  } out_word_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] idx;
    logic [CfgDatW-1:0] data;
  } cfg_word_t;

  // serial divider control
  typedef struct packed {
    logic start;
    logic busy;
    logic quot_lsb;
  } div_ctl_t;

endpackage
`default_nettype wire

// File: hw/rtl/atbl_if.sv
`default_nettype none
interface atbl_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/atbl_div.sv
`default_nettype none
// Restoring bit-serial divider: one quotient bit per cycle, only the LSB is kept.
module atbl_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [15:0] divisor_i,
  output atbl_pkg::div_ctl_t ctl_o
);
  import atbl_pkg::*;

  logic [31:0] num_q, num_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        qb_q, qb_d;
  logic [16:0] trial;
  logic [17:0] diff;

  always_comb begin
    num_d = num_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    qb_d  = qb_q;
    trial = {rem_q[15:0], num_q[31]};
    diff  = {1'b0, trial} - {2'b00, den_q};
    if (start_i) begin
      num_d = dividend_i;
      rem_d = '0;
      den_d = (divisor_i == '0) ? 16'd1 : divisor_i;
      cnt_d = 6'd32;
    end else if (cnt_q != '0) begin
      num_d = {num_q[30:0], 1'b0};
      cnt_d = cnt_q - 6'd1;
      if (!diff[17]) begin
        rem_d = diff[16:0];
        qb_d  = 1'b1;
      end else begin
        rem_d = trial;
        qb_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      qb_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      qb_q  <= qb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign ctl_o.start    = start_i;
  assign ctl_o.busy     = (cnt_q != '0);
  assign ctl_o.quot_lsb = qb_q;
endmodule
`default_nettype wire

// File: hw/rtl/atbl_smul.sv
`default_nettype none
// Shift-add signed multiplier: 4 multiplier bits per cycle.
module atbl_smul (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [24:0] a_i,
  input  wire logic signed [24:0] b_i,
  output logic                    busy_o,
  output logic signed [49:0]      p_o
);
  import atbl_pkg::*;

  logic signed [49:0] acc_q, acc_d;
  logic signed [49:0] mcand_q, mcand_d;
  logic [27:0]        mplr_q, mplr_d;
  logic [2:0]         cnt_q, cnt_d;
  logic signed [49:0] part;

  always_comb begin
    acc_d   = acc_q;
    mcand_d = mcand_q;
    mplr_d  = mplr_q;
    cnt_d   = cnt_q;
    part    = '0;
    if (start_i) begin
      acc_d   = '0;
      mcand_d = 50'(a_i);
      mplr_d  = {{3{b_i[24]}}, b_i};
      cnt_d   = 3'd7;
    end else if (cnt_q != '0) begin
      // top bit of the top digit carries negative weight (two's complement)
      if (cnt_q == 3'd1) part = mcand_q * $signed({1'b0, mplr_q[2:0]}) - (mcand_q <<< 3)
                                * $signed({1'b0, mplr_q[3]});
      else part = mcand_q * $signed({1'b0, mplr_q[3:0]});
      acc_d   = acc_q + part;
      mcand_d = mcand_q <<< 4;
      mplr_d  = {4'b0, mplr_q[27:4]};
      cnt_d   = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    mcand_q <= mcand_d;
    mplr_q  <= mplr_d;
  end

  assign busy_o = (cnt_q != '0);
  assign p_o    = acc_q;
endmodule
`default_nettype wire

// File: hw/rtl/accel_turn_brake_light_controller_unit.sv
`default_nettype none
// Accelerometer turn/brake light controller. One input word per sensor tick
// gives one output word. The shared 4-bit-digit multiplier is used seven
// times in turn with a valid sample: two per filter, the speed increment
// and the two squares. Each filter product is started, waited for and
// collected in turn; the next word can be taken once the result register
// has loaded and the controller is back in idle. Without a valid sample the
// filters are skipped and the 32-step serial divider for the blink phase,
// started at acceptance, sets the pace. A result waiting in the output
// register does not stop the next word from being accepted; that word holds
// in its final lamp stage until the register frees. Configuration writes are
// never blocked; the user must make them only while no word is in flight,
// which the block itself does not enforce. Speed is in LSB*ms, filters in Q.8.
module accel_turn_brake_light_controller_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  atbl_if.sink      cfg,
  atbl_if.sink      in_w,
  atbl_if.source    out_w
);
  import atbl_pkg::*;

  // configuration
  logic signed [15:0] along_bias_q, lateral_bias_q, brake_thr_q;
  logic        hazard_q;
  logic [1:0]  manual_q;
  logic [14:0] turn_thr_q;
  logic [15:0] blink_half_q, hold_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      along_bias_q   <= '0;
      lateral_bias_q <= '0;
      hazard_q       <= 1'b0;
      manual_q       <= TURN_OFF;
      turn_thr_q     <= 15'd1838;
      brake_thr_q    <= -16'sd1504;
      blink_half_q   <= 16'd450;
      hold_q         <= 16'd2000;
    end else if (cfg.valid) begin
      case (reg_idx_e'(cfg.data.idx))
        REG_ALONG_BIAS:   along_bias_q   <= cfg.data.data;
        REG_LATERAL_BIAS: lateral_bias_q <= cfg.data.data;
        REG_HAZARD_ON:    hazard_q       <= cfg.data.data[0];
        REG_MANUAL_TURN:  manual_q       <= cfg.data.data[1:0];
        REG_TURN_THR:     turn_thr_q     <= cfg.data.data[14:0];
        REG_BRAKE_THR:    brake_thr_q    <= cfg.data.data;
        REG_BLINK_HALF:   blink_half_q   <= cfg.data.data;
        REG_HOLD:         hold_q         <= cfg.data.data;
        default: ;
      endcase
    end
  end

  // state
  state_e state_q, state_d;
  logic [2:0] step_q, step_d;
  in_word_t   item_q, item_d;
  logic [31:0] last_q, last_d, since_q, since_d;
  logic signed [23:0] al_q, al_d, la_q, la_d;
  logic [24:0] spd_q, spd_d;
  logic        still_q, still_d;
  logic [5:0]  dt_q, dt_d;
  logic signed [49:0] tmp_q, tmp_d;
  out_word_t   res_q, res_d;
  logic        ovalid_q, ovalid_d;

  // shared multiplier
  logic               m_start;
  logic signed [24:0] m_a, m_b;
  logic               m_busy;
  logic signed [49:0] m_p;

  atbl_smul u_mul (
    .clk_i, .rst_ni, .start_i(m_start), .a_i(m_a), .b_i(m_b),
    .busy_o(m_busy), .p_o(m_p)
  );

  logic     d_start;
  div_ctl_t d_ctl;

  atbl_div u_div (
    .clk_i, .rst_ni, .start_i(d_start), .dividend_i(in_w.data.now_ms),
    .divisor_i(blink_half_q), .ctl_o(d_ctl)
  );

  assign in_w.ready  = (state_q == ST_IDLE);
  assign out_w.valid = ovalid_q;
  assign out_w.data  = res_q;

  // helpers
  logic signed [16:0] diff17;
  logic signed [15:0] dsat;
  logic [31:0]        dtraw, stilld;
  logic signed [51:0] facc;
  logic signed [27:0] fsh;
  logic signed [41:0] ssh;
  logic signed [27:0] spsum;
  logic [49:0]        sq_sum;
  logic               low;
  logic               blink, autoen, lft, rgt, tail;
  logic signed [39:0] thr_q8;
  logic signed [23:0] brake_q8;
  logic [24:0]        spd_fin;

  localparam logic [49:0] StillQ8 = 50'(StillLsb) << 8;
  localparam logic [49:0] StillSq = StillQ8 * StillQ8;

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    item_d   = item_q;
    last_d   = last_q;
    since_d  = since_q;
    al_d     = al_q;
    la_d     = la_q;
    spd_d    = spd_q;
    still_d  = still_q;
    dt_d     = dt_q;
    tmp_d    = tmp_q;
    res_d    = res_q;
    ovalid_d = ovalid_q;
    m_start  = 1'b0;
    m_a      = '0;
    m_b      = '0;
    d_start  = 1'b0;
    diff17   = '0;
    dsat     = '0;
    facc     = '0;
    fsh      = '0;
    ssh      = '0;
    spsum    = '0;
    sq_sum   = '0;
    low      = 1'b0;
    blink    = 1'b0;
    autoen   = 1'b0;
    lft      = 1'b0;
    rgt      = 1'b0;
    tail     = 1'b0;
    thr_q8   = '0;
    brake_q8 = '0;
    spd_fin  = spd_q;
    dtraw    = in_w.data.now_ms - last_q;
    stilld   = item_q.now_ms - since_q;

    if (out_w.valid && out_w.ready) ovalid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_w.valid && in_w.ready) begin
          item_d  = in_w.data;
          d_start = 1'b1;
          if (dtraw == '0) dt_d = 6'd1;
          else if (dtraw > 32'd50) dt_d = 6'd50;
          else dt_d = dtraw[5:0];
          last_d  = in_w.data.now_ms;
          step_d  = 3'd0;
          state_d = item_d.sample_valid ? ST_FILT : ST_SPEED;
        end
      end
      ST_FILT: begin
        // step 0: 218*d(along); 1: 38*y(along), combine; 2,3 lateral
        if (step_q[0] == 1'b0) diff17 = step_q[1]
          ? 17'(item_q.accel_lateral_raw) - 17'(lateral_bias_q)
          : 17'(item_q.accel_along_raw) - 17'(along_bias_q);
        if (diff17 > 17'sd32767) dsat = 16'sh7FFF;
        else if (diff17 < -17'sd32768) dsat = 16'sh8000;
        else dsat = diff17[15:0];
        if (!m_busy && !m_start) begin
          case (step_q)
            3'd0, 3'd2: begin
              m_start = 1'b1;
              m_a = 25'(dsat);
              m_b = 25'($signed({1'b0, AlphaNum}));
              step_d = step_q + 3'd1;
              state_d = ST_DIV; // wait for the product
            end
            3'd1, 3'd3: begin
              m_start = 1'b1;
              m_a = step_q[1] ? 25'(la_q) : 25'(al_q);
              m_b = 25'($signed({1'b0, AlphaRem}));
              step_d = step_q + 3'd1;
              state_d = ST_DIV;
            end
            default: begin
              step_d  = 3'd0;
              state_d = ST_SPEED;
            end
          endcase
        end
      end
      ST_DIV: begin
        // product wait/collect inside the filter sequence
        if (!m_busy) begin
          if (step_q[0]) begin
            tmp_d = m_p <<< 8;
          end else begin
            facc = 52'(tmp_q) + 52'(m_p) + 52'sd128;
            fsh  = 28'(facc >>> 8);
            if (step_q[1]) begin
              // step now 2 means along finished
              if (fsh > 28'sd8388607) al_d = 24'sh7FFFFF;
              else if (fsh < -28'sd8388608) al_d = 24'sh800000;
              else al_d = fsh[23:0];
            end else begin
              if (fsh > 28'sd8388607) la_d = 24'sh7FFFFF;
              else if (fsh < -28'sd8388608) la_d = 24'sh800000;
              else la_d = fsh[23:0];
            end
          end
          state_d = ST_FILT;
          if (step_q == 3'd4) step_d = 3'd4;
        end
      end
      ST_SPEED: begin
        if (!m_busy && !m_start) begin
          case (step_q)
            3'd0: begin
              m_start = 1'b1;
              m_a = 25'(al_q);
              m_b = 25'($signed({19'd0, dt_q}));
              step_d = 3'd1;
            end
            3'd1: begin
              ssh   = 42'(m_p >>> 8);
              spsum = 28'($signed({3'b0, spd_q})) + 28'(ssh);
              if (spsum < 0) spd_d = '0;
              else if (spsum > 28'($signed({3'b0, SpeedMax}))) spd_d = SpeedMax;
              else spd_d = spsum[24:0];
              m_start = 1'b1;
              m_a = 25'(al_q);
              m_b = 25'(al_q);
              step_d = 3'd2;
            end
            default: begin
              tmp_d   = m_p;
              m_start = 1'b1;
              m_a = 25'(la_q);
              m_b = 25'(la_q);
              step_d  = 3'd0;
              state_d = ST_MAG;
            end
          endcase
        end
      end
      ST_MAG: begin
        // hold here while the previous result still waits in the output register
        if (!m_busy && !m_start && !d_ctl.busy && (!ovalid_q || out_w.ready)) begin
          sq_sum = 50'(tmp_q) + 50'(m_p);
          low = sq_sum < StillSq;
          spd_fin = spd_q;
          if (low) begin
            if (!still_q) begin
              still_d = 1'b1;
              since_d = item_q.now_ms;
              stilld  = '0;
            end
            if (stilld >= {16'd0, hold_q}) spd_fin = '0;
          end else begin
            still_d = 1'b0;
          end
          spd_d  = spd_fin;
          blink  = !d_ctl.quot_lsb;
          autoen = spd_fin >= SpeedAutoMin;
          thr_q8 = 40'($signed({1'b0, turn_thr_q})) <<< 8;
          brake_q8 = 24'(brake_thr_q) <<< 8;
          if (hazard_q) begin
            lft = blink; rgt = blink; tail = blink;
          end else begin
            lft = ((manual_q == TURN_LEFT) || (autoen && 40'(la_q) <= -thr_q8)) && blink;
            rgt = ((manual_q == TURN_RIGHT) || (autoen && 40'(la_q) >= thr_q8)) && blink;
            tail = al_q <= brake_q8;
          end
          res_d.turn_left        = lft;
          res_d.turn_right       = rgt;
          res_d.tail_light       = tail;
          res_d.speed_estimate   = spd_fin;
          res_d.along_filtered   = al_q;
          res_d.lateral_filtered = la_q;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        ovalid_d = 1'b1;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= '0;
      last_q   <= '0;
      since_q  <= '0;
      al_q     <= '0;
      la_q     <= '0;
      spd_q    <= '0;
      still_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      last_q   <= last_d;
      since_q  <= since_d;
      al_q     <= al_d;
      la_q     <= la_d;
      spd_q    <= spd_d;
      still_q  <= still_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    dt_q   <= dt_d;
    tmp_q  <= tmp_d;
    res_q  <= res_d;
  end
endmodule
`default_nettype wire
